/* sv/u8d_pkg.sv */
// Package for the UTF-8 stream decoder: status codes, field widths and the result record.
// Has no dependencies. The interfaces and the top level import it.
`default_nettype none

package u8d_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned CpW     = 32;
    localparam int unsigned LenW    = 3;
    localparam int unsigned StatusW = 2;

    typedef enum logic [StatusW-1:0] {
        ST_OK    = 2'd0,
        ST_STRAY = 2'd1,
        ST_TRUNC = 2'd2
    } status_t;

    localparam logic [LenW-1:0] LEN_NONE = 3'd0;
    localparam logic [LenW-1:0] LEN_1    = 3'd1;
    localparam logic [LenW-1:0] LEN_2    = 3'd2;
    localparam logic [LenW-1:0] LEN_3    = 3'd3;
    localparam logic [LenW-1:0] LEN_4    = 3'd4;
    localparam logic [LenW-1:0] LEN_5    = 3'd5;
    localparam logic [LenW-1:0] LEN_6    = 3'd6;

    typedef struct packed {
        logic [CpW-1:0]  char_value;
        logic [LenW-1:0] seq_length;
        status_t         status;
    } result_t;

endpackage

`default_nettype wire

/* sv/u8d_byte_if.sv */
// Byte input channel of the UTF-8 stream decoder: valid/ready with one byte and its end flag.
// Depends on u8d_pkg for widths.
`default_nettype none

interface u8d_byte_if
    import u8d_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] in_byte;
    logic             end_of_buffer;

    modport source (output valid, output in_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

/* sv/u8d_result_if.sv */
// Result channel of the UTF-8 stream decoder: valid/ready with code point, length and status.
// Depends on u8d_pkg for widths.
`default_nettype none

interface u8d_result_if
    import u8d_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CpW-1:0]      char_value;
    logic [LenW-1:0]     seq_length;
    logic [StatusW-1:0]  status;

    modport source (output valid, output char_value, output seq_length, output status,
                    input ready);
    modport sink   (input valid, input char_value, input seq_length, input status,
                    output ready);
endinterface

`default_nettype wire

/* sv/utf8_stream_decoder_top.sv */
// Top level of the UTF-8 stream decoder (legacy 1 to 6 byte forms).
// Depends on u8d_pkg, u8d_byte_if and u8d_result_if.
//
//   channel     dir   beat contents
//   byte_in     in    in_byte[7:0], end_of_buffer
//   result_out  out   char_value[31:0], seq_length[2:0], status[1:0]
//
// One byte is taken per cycle while the skid is empty; the result of the byte that
// ends its sequence is registered in the same cycle as the decode state updates.
// A result register plus a skid register hold one extra result while the output
// stalls; byte_in.ready drops only when the skid is full.
// Reset returns the decoder to idle and empties both output entries.
`default_nettype none

module utf8_stream_decoder_top
    import u8d_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    u8d_byte_if.sink      byte_in,
    u8d_result_if.source  result_out
);

    logic [LenW-1:0] rem_reg, rem_next;
    logic [CpW-1:0]  acc_reg, acc_next;
    logic [LenW-1:0] total_reg, total_next;

    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;
    result_t skid_reg, skid_next;
    logic    skid_valid_reg, skid_valid_next;

    logic            accept;
    logic            pop;
    logic            produce;
    result_t         res;
    logic [ByteW-1:0] b;
    logic            last;
    logic [LenW-1:0] rem_dec;
    logic [CpW-1:0]  cont_bits;

    assign b      = byte_in.in_byte;
    assign last   = byte_in.end_of_buffer;
    assign accept = byte_in.valid && byte_in.ready;
    assign pop    = out_valid_reg && result_out.ready;

    assign rem_dec = rem_reg - LEN_1;

    always_comb
    begin
        case (rem_dec)
            3'd0:    cont_bits = {26'd0, b[5:0]};
            3'd1:    cont_bits = {20'd0, b[5:0], 6'd0};
            3'd2:    cont_bits = {14'd0, b[5:0], 12'd0};
            3'd3:    cont_bits = {8'd0, b[5:0], 18'd0};
            3'd4:    cont_bits = {2'd0, b[5:0], 24'd0};
            default: cont_bits = '0;
        endcase
    end

    // decode one byte
    always_comb
    begin
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        total_next = total_reg;
        produce    = 1'b0;
        res        = '{char_value: '0, seq_length: LEN_NONE, status: ST_OK};

        if (rem_reg == LEN_NONE)
        begin
            if (b inside {[8'h00:8'h7F]})
            begin
                produce = 1'b1;
                res     = '{char_value: {24'd0, b}, seq_length: LEN_1, status: ST_OK};
            end
            else if (b inside {[8'h80:8'hBF]})
            begin
                produce = 1'b1;
                res     = '{char_value: '0, seq_length: LEN_NONE, status: ST_STRAY};
            end
            else if (last)
            begin
                produce = 1'b1;
                res     = '{char_value: '0, seq_length: LEN_NONE, status: ST_TRUNC};
            end
            else
            begin
                if (b inside {[8'hC0:8'hDF]})
                begin
                    total_next = LEN_2;
                    acc_next   = {21'd0, b[4:0], 6'd0};
                end
                else if (b inside {[8'hE0:8'hEF]})
                begin
                    total_next = LEN_3;
                    acc_next   = {16'd0, b[3:0], 12'd0};
                end
                else if (b inside {[8'hF0:8'hF7]})
                begin
                    total_next = LEN_4;
                    acc_next   = {11'd0, b[2:0], 18'd0};
                end
                else if (b inside {[8'hF8:8'hFB]})
                begin
                    total_next = LEN_5;
                    acc_next   = {6'd0, b[1:0], 24'd0};
                end
                else
                begin
                    total_next = LEN_6;
                    acc_next   = {b[1:0], 30'd0};
                end
                rem_next = total_next - LEN_1;
            end
        end
        else
        begin
            rem_next = rem_dec;
            acc_next = acc_reg | cont_bits;
            if (rem_dec == LEN_NONE)
            begin
                produce    = 1'b1;
                res        = '{char_value: acc_next, seq_length: total_reg, status: ST_OK};
                acc_next   = '0;
                total_next = LEN_NONE;
            end
            else if (last)
            begin
                produce    = 1'b1;
                res        = '{char_value: '0, seq_length: LEN_NONE, status: ST_TRUNC};
                rem_next   = LEN_NONE;
                acc_next   = '0;
                total_next = LEN_NONE;
            end
        end

        if (produce && (rem_reg == LEN_NONE))
        begin
            rem_next   = LEN_NONE;
            acc_next   = '0;
            total_next = LEN_NONE;
        end
    end

    // output register and skid
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = res;
                skid_valid_next = accept && produce;
            end
            else
            begin
                out_next       = res;
                out_valid_next = accept && produce;
            end
        end
        else if (accept && produce)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg        <= LEN_NONE;
            acc_reg        <= '0;
            total_reg      <= LEN_NONE;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                rem_reg   <= rem_next;
                acc_reg   <= acc_next;
                total_reg <= total_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign byte_in.ready         = !skid_valid_reg;
    assign result_out.valid      = out_valid_reg;
    assign result_out.char_value = out_reg.char_value;
    assign result_out.seq_length = out_reg.seq_length;
    assign result_out.status     = out_reg.status;

endmodule

`default_nettype wire

/* tb/utf8_stream_decoder_top_tb.sv */
`timescale 1ns / 1ps
// Testbench for utf8_stream_decoder_top: queued byte stimulus, in-bench decode predictor,
// result scoreboard. Depends on u8d_pkg, u8d_byte_if, u8d_result_if and the top level.

module utf8_stream_decoder_top_tb;
    import u8d_pkg::*;

    typedef struct {
        logic [ByteW-1:0] value;
        logic             last;
    } stream_byte_t;

    logic clk;
    logic rst_n;

    u8d_byte_if   byte_in ();
    u8d_result_if result_out ();

    utf8_stream_decoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .result_out (result_out)
    );

    stream_byte_t pending_bytes[$];
    result_t      expected_cps[$];

    int unsigned n_queued;
    int unsigned n_taken;
    int unsigned n_errors;
    int unsigned src_gap_max;
    int unsigned snk_gap_max;
    int unsigned src_wait;
    int unsigned snk_wait;
    logic        hold_off;

    logic [LenW-1:0] dec_left;
    logic [CpW-1:0]  dec_acc;
    logic [LenW-1:0] dec_total;

    function automatic bit decode_byte(input logic [ByteW-1:0] b, input logic last,
                                       output result_t cp);
        logic [LenW-1:0] total;
        logic [CpW-1:0]  lead_bits;
        bit              emit;
        cp.char_value = '0;
        cp.seq_length = LEN_NONE;
        cp.status     = ST_OK;
        emit          = 1'b0;
        if (dec_left == '0) begin
            if (b < 8'h80) begin
                cp.char_value = CpW'(b);
                cp.seq_length = LEN_1;
                emit          = 1'b1;
            end else if (b < 8'hC0) begin
                cp.status = ST_STRAY;
                emit      = 1'b1;
            end else begin
                if (b < 8'hE0) begin
                    total     = LEN_2;
                    lead_bits = CpW'(b & 8'h1F) << 6;
                end else if (b < 8'hF0) begin
                    total     = LEN_3;
                    lead_bits = CpW'(b & 8'h0F) << 12;
                end else if (b < 8'hF8) begin
                    total     = LEN_4;
                    lead_bits = CpW'(b & 8'h07) << 18;
                end else if (b < 8'hFC) begin
                    total     = LEN_5;
                    lead_bits = CpW'(b & 8'h03) << 24;
                end else begin
                    total     = LEN_6;
                    lead_bits = CpW'(b & 8'h03) << 30;
                end
                if (last) begin
                    cp.status = ST_TRUNC;
                    emit      = 1'b1;
                end else begin
                    dec_acc   = lead_bits;
                    dec_total = total;
                    dec_left  = total - 1'b1;
                end
            end
        end else begin
            dec_left = dec_left - 1'b1;
            dec_acc  = dec_acc | (CpW'(b & 8'h3F) << (6 * (dec_left % 5)));
            if (dec_left == '0) begin
                cp.char_value = dec_acc;
                cp.seq_length = dec_total;
                emit          = 1'b1;
            end else if (last) begin
                cp.status = ST_TRUNC;
                emit      = 1'b1;
            end
        end
        if (emit) begin
            dec_left  = '0;
            dec_acc   = '0;
            dec_total = '0;
        end
        return emit;
    endfunction

    task automatic push_byte(input logic [ByteW-1:0] value, input logic last);
        stream_byte_t sb;
        sb.value = value;
        sb.last  = last;
        pending_bytes.push_back(sb);
        n_queued++;
    endtask

    // Mostly well-formed sequences with random payload; the rest is raw noise.
    task automatic queue_random_text(input int unsigned count);
        int unsigned     target;
        int unsigned     len;
        logic [ByteW-1:0] b;
        target = n_queued + count;
        while (n_queued < target) begin
            if ($urandom_range(0, 99) < 85) begin
                len = $urandom_range(1, 6);
                case (len)
                    1: b = 8'($urandom_range(0, 8'h7F));
                    2: b = 8'hC0 + 8'($urandom_range(0, 31));
                    3: b = 8'hE0 + 8'($urandom_range(0, 15));
                    4: b = 8'hF0 + 8'($urandom_range(0, 7));
                    5: b = 8'hF8 + 8'($urandom_range(0, 3));
                    default: b = 8'hFC + 8'($urandom_range(0, 3));
                endcase
                push_byte(b, $urandom_range(0, 15) == 0);
                for (int i = 1; i < len; i++) begin
                    if ($urandom_range(0, 7) == 0)
                        b = 8'($urandom_range(0, 255));
                    else
                        b = 8'h80 | 8'($urandom_range(0, 63));
                    push_byte(b, $urandom_range(0, 15) == 0);
                end
            end else begin
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    task automatic wait_drained();
        while (n_taken != n_queued || expected_cps.size() != 0)
            @(negedge clk);
    endtask

    initial begin
        clk                      = 1'b0;
        rst_n                    = 1'b0;
        byte_in.valid            = 1'b0;
        byte_in.in_byte          = '0;
        byte_in.end_of_buffer    = 1'b0;
        result_out.ready         = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Long receiver stall while the sender keeps offering beats.
    initial begin
        hold_off = 1'b0;
        while (n_taken < 800)
            @(negedge clk);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk or negedge rst_n) begin
        result_t      cp;
        stream_byte_t sb;
        if (!rst_n) begin
            byte_in.valid         <= 1'b0;
            byte_in.in_byte       <= '0;
            byte_in.end_of_buffer <= 1'b0;
            src_wait              <= 0;
            dec_left              = '0;
            dec_acc               = '0;
            dec_total             = '0;
        end else begin
            if (byte_in.valid && byte_in.ready) begin
                n_taken++;
                if (decode_byte(byte_in.in_byte, byte_in.end_of_buffer, cp))
                    expected_cps.push_back(cp);
            end
            if (!byte_in.valid || byte_in.ready) begin
                if (src_wait != 0) begin
                    src_wait      <= src_wait - 1;
                    byte_in.valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    sb = pending_bytes.pop_front();
                    byte_in.in_byte       <= sb.value;
                    byte_in.end_of_buffer <= sb.last;
                    byte_in.valid         <= 1'b1;
                    src_wait              <= $urandom_range(0, src_gap_max);
                end else begin
                    byte_in.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        result_t     cp;
        int unsigned w;
        if (!rst_n) begin
            result_out.ready <= 1'b0;
            snk_wait         <= 0;
        end else begin
            w = 0;
            if (result_out.valid && result_out.ready) begin
                if (expected_cps.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got cp=%h len=%0d st=%0d",
                             $time, result_out.char_value, result_out.seq_length,
                             result_out.status);
                    n_errors++;
                end else begin
                    cp = expected_cps.pop_front();
                    if (result_out.char_value !== cp.char_value ||
                        result_out.seq_length !== cp.seq_length ||
                        result_out.status !== cp.status) begin
                        $display("%0t: mismatch: expected cp=%h len=%0d st=%0d,",
                                 $time, cp.char_value, cp.seq_length, cp.status,
                                 " got cp=%h len=%0d st=%0d",
                                 result_out.char_value, result_out.seq_length,
                                 result_out.status);
                        n_errors++;
                    end
                end
                w = $urandom_range(0, snk_gap_max);
            end
            if (hold_off) begin
                result_out.ready <= 1'b0;
            end else if (w != 0) begin
                result_out.ready <= 1'b0;
                snk_wait         <= w - 1;
            end else if (!result_out.ready) begin
                if (snk_wait != 0)
                    snk_wait <= snk_wait - 1;
                else
                    result_out.ready <= 1'b1;
            end
        end
    end

    initial begin
        n_queued    = 0;
        n_taken     = 0;
        n_errors    = 0;
        src_gap_max = 5;
        snk_gap_max = 5;

        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hDF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hEF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hF7, 1'b0);
        repeat (3) push_byte(8'hBF, 1'b0);
        push_byte(8'hFB, 1'b0);
        repeat (4) push_byte(8'hBF, 1'b0);
        // six-byte lead with unchecked continuation values
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h3F, 1'b0);
        push_byte(8'hC0, 1'b0);
        push_byte(8'hBF, 1'b0);
        // end flag on a lead, mid-sequence, and on the completing byte
        push_byte(8'hC0, 1'b1);
        push_byte(8'hE0, 1'b0);
        push_byte(8'h80, 1'b1);
        push_byte(8'hC2, 1'b0);
        push_byte(8'hA9, 1'b1);
        wait_drained();

        src_gap_max = 0;
        snk_gap_max = 0;
        queue_random_text(400);
        wait_drained();

        for (int k = 0; k < 6; k++) begin
            src_gap_max = $urandom_range(0, 1) * 5;
            snk_gap_max = (k == 0) ? 5 : $urandom_range(0, 1) * 5;
            queue_random_text(260);
        end
        wait_drained();
        repeat (10) @(posedge clk);

        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
